// ===== src/heat_conduction_rate_sweep_assert.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the heat conduction rate sweep.
// Each macro places one labeled concurrent assertion that is clocked on the
// given clock and switched off while the active-low reset is asserted.
// ---------------------------------------------------------------------------
`ifndef HEAT_CONDUCTION_RATE_SWEEP_ASSERT_SVH
`define HEAT_CONDUCTION_RATE_SWEEP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define HCRS_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define HCRS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/hcrs_pkg.sv =====
// ---------------------------------------------------------------------------
// hcrs_pkg
// Shared widths, limits, register indexes and the divider request type of
// the heat conduction rate sweep.
// ---------------------------------------------------------------------------
package hcrs_pkg;

    localparam int Q_W    = 32;              // Q16.16 words
    localparam int HWIN_W = 31;              // half window register
    localparam int RATE_W = 48;              // Q8.40 result
    localparam int IDX_W  = 12;              // cell index
    localparam int NUM_W  = Q_W + 1;         // flux difference and capacity
    localparam int PROD_W = 2 * Q_W;         // multiplier product
    localparam int MAG_W  = PROD_W - 16;     // product after the Q16.16 shift

    localparam int MAX_CELLS = 4096;
    localparam int CNT_SPAN  = (MAX_CELLS < (1 << IDX_W)) ? MAX_CELLS : (1 << IDX_W);
    localparam logic [IDX_W-1:0] CNT_LAST = IDX_W'(CNT_SPAN - 1);

    // Shared divider geometry: the widest dividend is the flux difference
    // shifted up by 24 bits, the widest divisor is the 33 bit capacity.
    localparam int DVD_W  = NUM_W + 24;
    localparam int DIV_W  = NUM_W;
    localparam int STEP_W = $clog2(DVD_W + 1);

    localparam logic [STEP_W-1:0] STEPS_CAP   = STEP_W'(DVD_W);
    localparam logic [STEP_W-1:0] STEPS_THICK = STEP_W'(RATE_W);
    localparam logic [STEP_W-1:0] STEPS_GRAD  = STEP_W'(Q_W);

    localparam logic [RATE_W-1:0] RATE_POS_MAX = {1'b0, {(RATE_W-1){1'b1}}};
    localparam logic [RATE_W-1:0] RATE_NEG_MAG = {1'b1, {(RATE_W-1){1'b0}}};
    localparam logic [Q_W-1:0]    Q_POS_MAX    = {1'b0, {(Q_W-1){1'b1}}};
    localparam logic [Q_W-1:0]    Q_NEG_MAG    = {1'b1, {(Q_W-1){1'b0}}};

    // Configuration register indexes.
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_CONDUCTIVITY = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_VOL_CAPACITY = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GEO_FLUX     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FREEZE_TEMP  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_HALF_WINDOW  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_LATENT_EXTRA = 3'd5;

    localparam logic [Q_W-1:0]    CONDUCTIVITY_RST = 32'd65536;
    localparam logic [Q_W-1:0]    VOL_CAPACITY_RST = 32'd2000000;
    localparam logic [HWIN_W-1:0] HALF_WINDOW_RST  = 31'd65536;

    typedef struct packed {
        logic              start;
        logic [STEP_W-1:0] steps;
    } t_div_req;

endpackage

// ===== src/hcrs_mul.sv =====
// ---------------------------------------------------------------------------
// hcrs_mul
// Unsigned 32 by 32 multiplier with a registered product.
// ---------------------------------------------------------------------------
module hcrs_mul (
    input  logic                        i_clk,
    input  logic [hcrs_pkg::Q_W-1:0]    i_a,
    input  logic [hcrs_pkg::Q_W-1:0]    i_b,
    output logic [hcrs_pkg::PROD_W-1:0] o_p
);
    import hcrs_pkg::*;

    logic [PROD_W-1:0] r_p;

    always_ff @(posedge i_clk) begin
        r_p <= PROD_W'(i_a) * PROD_W'(i_b);
    end

    assign o_p = r_p;

endmodule

// ===== src/hcrs_div.sv =====
// ---------------------------------------------------------------------------
// hcrs_div
// Shared restoring radix-2 divider, one quotient bit per cycle. The dividend
// is loaded top aligned together with a starting partial remainder; after
// the requested number of steps the quotient sits in the low bits.
// ---------------------------------------------------------------------------
module hcrs_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  hcrs_pkg::t_div_req         i_req,
    input  logic [hcrs_pkg::DVD_W-1:0] i_dividend,
    input  logic [hcrs_pkg::DIV_W-1:0] i_rem_init,
    input  logic [hcrs_pkg::DIV_W-1:0] i_divisor,
    output logic                       o_done,
    output logic [hcrs_pkg::DVD_W-1:0] o_quotient
);
    import hcrs_pkg::*;

    logic              r_busy;
    logic              r_done;
    logic [STEP_W-1:0] r_cnt;
    logic [DIV_W-1:0]  r_rem;
    logic [DIV_W-1:0]  r_dsr;
    logic [DVD_W-1:0]  r_dvd;

    logic [DIV_W:0] trial;
    logic [DIV_W:0] diff;
    logic           ge;

    always_comb begin
        trial = {r_rem, r_dvd[DVD_W-1]};
        diff  = trial - {1'b0, r_dsr};
        ge    = (trial >= {1'b0, r_dsr});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_req.steps;
            end else if (r_busy) begin
                r_cnt <= r_cnt - STEP_W'(1);
                if (r_cnt == STEP_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= i_rem_init;
            r_dsr <= i_divisor;
            r_dvd <= i_dividend;
        end else if (r_busy) begin
            // The remainder stays below the divisor, so the top bit drops.
            r_rem <= ge ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
            r_dvd <= {r_dvd[DVD_W-2:0], ge};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_dvd;

endmodule

// ===== src/heat_conduction_rate_sweep.sv =====
// ---------------------------------------------------------------------------
// heat_conduction_rate_sweep
// Temperature rate of change for every cell of a one-dimensional
// finite-volume column, streamed bottom to top.
// ---------------------------------------------------------------------------
// Usage: cells enter on the input channel (i_valid / o_stall), bottom cell
// first, the top cell flagged by i_is_top. A cell's rate leaves on the output
// channel (o_valid / i_stall) once the next cell has arrived, because that
// cell carries the factor of the edge between them; a top item that follows
// a held cell gives two rates, the one of the cell below it and its own with
// o_sweep_done set. Constants are to be written on the cfg port (always ready)
// only while the block idles; the block itself does not enforce this. The
// bottom cell of a column, unless it is also the top, is only stored. Every
// other cell passes through the shared radix-2 divider up to twice (57 steps
// by the capacity, then 48 steps by the thickness) besides sequencing and
// multiplies. A top item also needs a 32 step divide for the surface
// gradient and, with a cell held below it, a second rate computation. One
// item is worked at a time. A finished item waits in the output register;
// when the receiver stalls, the next rate waits in its emit step until that
// register is taken. Reset (synchronous, active low) empties the column and
// loads the default constants.
// ---------------------------------------------------------------------------
module heat_conduction_rate_sweep (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // Cell items.
    input  logic                                 i_valid,
    output logic                                 o_stall,
    input  logic signed [hcrs_pkg::Q_W-1:0]      i_temperature,
    input  logic        [hcrs_pkg::Q_W-1:0]      i_edge_factor,
    input  logic        [hcrs_pkg::Q_W-1:0]      i_thickness,
    input  logic signed [hcrs_pkg::Q_W-1:0]      i_surface_temp,
    input  logic                                 i_is_top,
    // Rate items.
    output logic                                 o_valid,
    input  logic                                 i_stall,
    output logic signed [hcrs_pkg::RATE_W-1:0]   o_rate,
    output logic        [hcrs_pkg::IDX_W-1:0]    o_cell_index,
    output logic                                 o_sweep_done,
    // Configuration writes.
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic        [hcrs_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic        [hcrs_pkg::Q_W-1:0]      i_cfg_data
);
    import hcrs_pkg::*;

    // Sequencer states.
    localparam logic [3:0] S_IDLE  = 4'd0;   // waiting for a cell
    localparam logic [3:0] S_IMUL  = 4'd1;   // edge factor times temperature step
    localparam logic [3:0] S_IGRAD = 4'd2;   // inner gradient from the product
    localparam logic [3:0] S_FMUL  = 4'd3;   // conductivity times gradient
    localparam logic [3:0] S_FLUX  = 4'd4;   // upper edge flux from the product
    localparam logic [3:0] S_RATE  = 4'd5;   // flux difference, capacity, divide start
    localparam logic [3:0] S_DIV1  = 4'd6;   // divide by capacity
    localparam logic [3:0] S_DIV2  = 4'd7;   // divide by thickness
    localparam logic [3:0] S_EMIT  = 4'd8;   // load the output register
    localparam logic [3:0] S_TGRAD = 4'd9;   // surface gradient setup
    localparam logic [3:0] S_TDIV  = 4'd10;  // surface gradient divide

    function automatic logic [Q_W-1:0] sat_mag(input logic neg, input logic [MAG_W-1:0] m);
        logic [Q_W-1:0] lim;
        lim = neg ? Q_NEG_MAG : Q_POS_MAX;
        return (m > MAG_W'(lim)) ? lim : m[Q_W-1:0];
    endfunction

    function automatic logic [Q_W-1:0] sat32(input logic neg, input logic [MAG_W-1:0] m);
        logic [Q_W-1:0] mm;
        mm = sat_mag(neg, m);
        return neg ? (Q_W'(0) - mm) : mm;
    endfunction

    // Configuration registers.
    logic [Q_W-1:0]    r_cond;
    logic [Q_W-1:0]    r_vcap;
    logic [Q_W-1:0]    r_geo;
    logic [Q_W-1:0]    r_freeze;
    logic [HWIN_W-1:0] r_hwin;
    logic [Q_W-1:0]    r_latent;

    // Control.
    logic [3:0]       r_state;
    logic [3:0]       n_state;
    logic             r_have_prev;
    logic [IDX_W-1:0] r_count;
    logic             r_phase;       // 0: rate of the held cell, 1: rate of the top cell
    logic             r_ovalid;

    // Current item and held cell.
    logic [Q_W-1:0] r_t;
    logic [Q_W-1:0] r_ef;
    logic [Q_W-1:0] r_thick;
    logic [Q_W-1:0] r_ts;
    logic           r_top;
    logic [Q_W-1:0] r_prev_t;
    logic [Q_W-1:0] r_prev_thick;
    logic [Q_W-1:0] r_lower;

    // Working values.
    logic           r_gneg;
    logic [Q_W-1:0] r_gmag;
    logic [Q_W-1:0] r_up;
    logic             r_rneg;
    logic [RATE_W-1:0] r_rmag;

    // Output register.
    logic [RATE_W-1:0] r_orate;
    logic [IDX_W-1:0]  r_oidx;
    logic              r_odone;

    // Shared units.
    logic [Q_W-1:0]    mul_a;
    logic [Q_W-1:0]    mul_b;
    logic [PROD_W-1:0] mul_p;
    t_div_req          div_req;
    logic [DVD_W-1:0]  div_dvd;
    logic [DIV_W-1:0]  div_rem;
    logic [DIV_W-1:0]  div_dsr;
    logic              div_done;
    logic [DVD_W-1:0]  div_q;

    // Combinational helpers.
    logic              out_free;
    logic [NUM_W-1:0]  idiff;
    logic [Q_W-1:0]    idiff_mag;
    logic [NUM_W-1:0]  tdiff;
    logic [Q_W-1:0]    tdiff_mag;
    logic              tdiff_sat;
    logic [NUM_W-1:0]  num;
    logic [NUM_W-1:0]  num_mag;
    logic [Q_W-1:0]    cap_t;
    logic [NUM_W-1:0]  wdiff;
    logic [NUM_W-1:0]  wdiff_mag;
    logic [NUM_W-1:0]  cap;
    logic [Q_W-1:0]    thk;
    logic [RATE_W-1:0] lim_now;
    logic              rate_div;
    logic              a_sat;
    logic [RATE_W-1:0] q48;

    hcrs_mul u_mul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (mul_p)
    );

    hcrs_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (div_req),
        .i_dividend (div_dvd),
        .i_rem_init (div_rem),
        .i_divisor  (div_dsr),
        .o_done     (div_done),
        .o_quotient (div_q)
    );

    always_comb begin
        out_free = !r_ovalid || !i_stall;

        // Temperature step across the inner edge below the current cell.
        idiff     = {r_t[Q_W-1], r_t} - {r_prev_t[Q_W-1], r_prev_t};
        idiff_mag = idiff[NUM_W-1] ? Q_W'(NUM_W'(0) - idiff) : idiff[Q_W-1:0];

        // Temperature step from the top cell to the surface. The gradient
        // overflows when the high dividend part already reaches the divisor.
        tdiff     = {r_ts[Q_W-1], r_ts} - {r_t[Q_W-1], r_t};
        tdiff_mag = tdiff[NUM_W-1] ? Q_W'(NUM_W'(0) - tdiff) : tdiff[Q_W-1:0];
        tdiff_sat = (Q_W'(tdiff_mag[Q_W-1:15]) >= r_thick);

        // Flux difference over the cell whose rate is being computed.
        num     = {r_lower[Q_W-1], r_lower} - {r_up[Q_W-1], r_up};
        num_mag = num[NUM_W-1] ? (NUM_W'(0) - num) : num;
        lim_now = num[NUM_W-1] ? RATE_NEG_MAG : RATE_POS_MAX;

        // Heat capacity, with the latent term inside the phase change window.
        cap_t     = r_phase ? r_t : r_prev_t;
        thk       = r_phase ? r_thick : r_prev_thick;
        wdiff     = {cap_t[Q_W-1], cap_t} - {r_freeze[Q_W-1], r_freeze};
        wdiff_mag = wdiff[NUM_W-1] ? (NUM_W'(0) - wdiff) : wdiff;
        cap       = {1'b0, r_vcap}
                  + ((wdiff_mag <= NUM_W'(r_hwin)) ? {1'b0, r_latent} : NUM_W'(0));
        rate_div  = (num_mag != '0) && (cap != '0) && (thk != '0);

        // Second divide: the quotient reaches 2^48 when the part of the
        // first quotient above bit 31 is not below the thickness.
        a_sat = (Q_W'(div_q[DVD_W-1:Q_W]) >= thk);
        q48   = div_q[RATE_W-1:0];

        // The multiplier is shared by the inner gradient and both fluxes.
        if (r_state == S_IMUL) begin
            mul_a = r_ef;
            mul_b = idiff_mag;
        end else begin
            mul_a = r_cond;
            mul_b = r_gmag;
        end

        div_req.start = 1'b0;
        div_req.steps = STEPS_CAP;
        div_dvd       = '0;
        div_rem       = '0;
        div_dsr       = '0;
        case (r_state)
            S_RATE: begin
                div_req.start = rate_div;
                div_req.steps = STEPS_CAP;
                div_dvd       = {num_mag, 24'b0};
                div_dsr       = cap;
            end
            S_DIV1: begin
                div_req.start = div_done && !a_sat;
                div_req.steps = STEPS_THICK;
                div_dvd       = {div_q[Q_W-1:0], 25'b0};
                div_rem       = DIV_W'(div_q[DVD_W-1:Q_W]);
                div_dsr       = {1'b0, thk};
            end
            S_TGRAD: begin
                div_req.start = (tdiff_mag != '0) && !tdiff_sat;
                div_req.steps = STEPS_GRAD;
                div_dvd       = {tdiff_mag[14:0], 42'b0};
                div_rem       = DIV_W'(tdiff_mag[Q_W-1:15]);
                div_dsr       = {1'b0, r_thick};
            end
            default: begin
                div_req.start = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    if (r_have_prev) begin
                        n_state = S_IMUL;
                    end else if (i_is_top) begin
                        n_state = S_TGRAD;
                    end
                end
            end
            S_IMUL:  n_state = S_IGRAD;
            S_IGRAD: n_state = S_FMUL;
            S_FMUL:  n_state = S_FLUX;
            S_FLUX:  n_state = S_RATE;
            S_RATE:  n_state = rate_div ? S_DIV1 : S_EMIT;
            S_DIV1: begin
                if (div_done) begin
                    n_state = a_sat ? S_EMIT : S_DIV2;
                end
            end
            S_DIV2: begin
                if (div_done) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    n_state = (!r_phase && r_top) ? S_TGRAD : S_IDLE;
                end
            end
            S_TGRAD: n_state = div_req.start ? S_TDIV : S_FMUL;
            S_TDIV: begin
                if (div_done) begin
                    n_state = S_FMUL;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cond   <= CONDUCTIVITY_RST;
            r_vcap   <= VOL_CAPACITY_RST;
            r_geo    <= '0;
            r_freeze <= '0;
            r_hwin   <= HALF_WINDOW_RST;
            r_latent <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_CONDUCTIVITY: r_cond   <= i_cfg_data;
                CFG_VOL_CAPACITY: r_vcap   <= i_cfg_data;
                CFG_GEO_FLUX:     r_geo    <= i_cfg_data;
                CFG_FREEZE_TEMP:  r_freeze <= i_cfg_data;
                CFG_HALF_WINDOW:  r_hwin   <= i_cfg_data[HWIN_W-1:0];
                CFG_LATENT_EXTRA: r_latent <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_have_prev <= 1'b0;
            r_count     <= '0;
            r_phase     <= 1'b0;
            r_ovalid    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_ovalid && !i_stall) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        // Without a held cell a top item goes straight to its own rate.
                        r_phase <= !r_have_prev;
                        if (!r_have_prev && !i_is_top) begin
                            r_have_prev <= 1'b1;
                        end
                    end
                end
                S_EMIT: begin
                    if (out_free) begin
                        r_ovalid <= 1'b1;
                        if (!r_phase) begin
                            r_count <= (r_count == CNT_LAST) ? '0 : r_count + IDX_W'(1);
                            if (r_top) begin
                                r_phase <= 1'b1;
                            end
                        end else begin
                            // End of the sweep: the column is empty again.
                            r_have_prev <= 1'b0;
                            r_count     <= '0;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    r_t     <= i_temperature;
                    r_ef    <= i_edge_factor;
                    r_thick <= i_thickness;
                    r_ts    <= i_surface_temp;
                    r_top   <= i_is_top;
                    if (!r_have_prev) begin
                        // The bottom cell's lower edge carries the geothermal flux.
                        r_lower <= r_geo;
                        if (!i_is_top) begin
                            r_prev_t     <= i_temperature;
                            r_prev_thick <= i_thickness;
                        end
                    end
                end
            end
            S_IGRAD: begin
                r_gneg <= idiff[NUM_W-1];
                r_gmag <= sat_mag(idiff[NUM_W-1], mul_p[PROD_W-1:16]);
            end
            S_FLUX: begin
                // Flux runs against the gradient.
                r_up <= sat32(!r_gneg && (r_gmag != '0), mul_p[PROD_W-1:16]);
            end
            S_RATE: begin
                r_rneg <= num[NUM_W-1];
                if (num_mag == '0) begin
                    r_rmag <= '0;
                end else if (!rate_div) begin
                    r_rmag <= lim_now;
                end
            end
            S_DIV1: begin
                if (div_done && a_sat) begin
                    r_rmag <= r_rneg ? RATE_NEG_MAG : RATE_POS_MAX;
                end
            end
            S_DIV2: begin
                if (div_done) begin
                    if (r_rneg) begin
                        r_rmag <= (q48 > RATE_NEG_MAG) ? RATE_NEG_MAG : q48;
                    end else begin
                        r_rmag <= (q48 > RATE_POS_MAX) ? RATE_POS_MAX : q48;
                    end
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    r_orate <= r_rneg ? (RATE_W'(0) - r_rmag) : r_rmag;
                    r_oidx  <= r_count;
                    r_odone <= r_phase;
                    if (!r_phase) begin
                        r_lower <= r_up;
                        if (!r_top) begin
                            r_prev_t     <= r_t;
                            r_prev_thick <= r_thick;
                        end
                    end
                end
            end
            S_TGRAD: begin
                r_gneg <= tdiff[NUM_W-1];
                if (tdiff_mag == '0) begin
                    r_gmag <= '0;
                end else if (tdiff_sat) begin
                    r_gmag <= tdiff[NUM_W-1] ? Q_NEG_MAG : Q_POS_MAX;
                end
            end
            S_TDIV: begin
                if (div_done) begin
                    r_gmag <= sat_mag(r_gneg, MAG_W'(div_q[Q_W-1:0]));
                end
            end
            default: ;
        endcase
    end

    assign o_stall      = (r_state != S_IDLE);
    assign o_valid      = r_ovalid;
    assign o_rate       = r_orate;
    assign o_cell_index = r_oidx;
    assign o_sweep_done = r_odone;
    assign o_cfg_ready  = 1'b1;

endmodule

// ===== src/hcrs_checker.sv =====
// ---------------------------------------------------------------------------
// hcrs_checker
// Port level checks of the heat conduction rate sweep, bound to the top.
// ---------------------------------------------------------------------------
`include "heat_conduction_rate_sweep_assert.svh"

module hcrs_checker (
    input logic                                  i_clk,
    input logic                                  i_rst_n,
    input logic                                  i_valid,
    input logic                                  o_stall,
    input logic signed [hcrs_pkg::Q_W-1:0]       i_temperature,
    input logic        [hcrs_pkg::Q_W-1:0]       i_edge_factor,
    input logic        [hcrs_pkg::Q_W-1:0]       i_thickness,
    input logic signed [hcrs_pkg::Q_W-1:0]       i_surface_temp,
    input logic                                  i_is_top,
    input logic                                  o_valid,
    input logic                                  i_stall,
    input logic signed [hcrs_pkg::RATE_W-1:0]    o_rate,
    input logic        [hcrs_pkg::IDX_W-1:0]     o_cell_index,
    input logic                                  o_sweep_done,
    input logic                                  i_cfg_valid,
    input logic                                  o_cfg_ready,
    input logic        [hcrs_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input logic        [hcrs_pkg::Q_W-1:0]       i_cfg_data
);

    // A waiting result item is held while the receiver stalls.
    `HCRS_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(o_rate) && $stable(o_cell_index) && $stable(o_sweep_done), "result changed under stall")

    // The block only turns busy after taking an item.
    `HCRS_ASSERT_SAME(a_busy_from_accept, i_clk, i_rst_n, $rose(o_stall), $past(i_valid) && !$past(o_stall), "busy without an accepted item")

    // A new result only appears out of work on an item.
    `HCRS_ASSERT_SAME(a_result_from_work, i_clk, i_rst_n, $rose(o_valid), $past(o_stall), "result without work")

    // A top item always needs work on its own rate.
    `HCRS_ASSERT_NEXT(a_top_busy, i_clk, i_rst_n, i_valid && !o_stall && i_is_top, o_stall, "top item taken without work")

endmodule

bind heat_conduction_rate_sweep hcrs_checker u_checker (.*);

// ===== tb/tb_heat_conduction_rate_sweep.sv =====
// ---------------------------------------------------------------------------
// tb_heat_conduction_rate_sweep
// Self-checking testbench for the heat conduction rate sweep. Columns of
// cells are streamed into the block under random idling and stalls, every
// accepted cell runs through a bit-exact model of the sweep arithmetic, and
// each rate that leaves the block is compared field by field with the oldest
// prediction. The run covers directed corner columns, several register
// settings with random columns, a long receiver hold-off and a column long
// enough to wrap the cell counter.
// ---------------------------------------------------------------------------
module tb_heat_conduction_rate_sweep;

    localparam int QW   = hcrs_pkg::Q_W;
    localparam int RW   = hcrs_pkg::RATE_W;
    localparam int IW   = hcrs_pkg::IDX_W;
    localparam int CW   = hcrs_pkg::CFG_IDX_W;

    // Idle settling time after a column, to cover anything still in flight
    // inside the block.
    localparam int SETTLE_CYCLES = 300;
    // Long receiver hold-off used once to back the block up into its input.
    localparam int HOLD_CYCLES   = 1000;
    // Detailed mismatch lines stop after this many; errors are still counted.
    localparam int REPORT_LIMIT  = 100;
    // Random columns per register setting, counted in cells.
    localparam int PHASE_CELLS   = 100;
    localparam int PHASES        = 8;

    typedef bit [63:0] mag_t;

    typedef struct {
        logic signed [QW-1:0] temperature;
        logic        [QW-1:0] edge_factor;
        logic        [QW-1:0] thickness;
        logic signed [QW-1:0] surface_temp;
        logic                 is_top;
    } cell_t;

    typedef struct {
        logic signed [RW-1:0] rate;
        logic        [IW-1:0] cell_index;
        logic                 sweep_done;
    } rate_item_t;

    typedef enum {SET_LOW, SET_HIGH, SET_MIXED} setting_e;

    // -----------------------------------------------------------------------
    // Scoreboard: a private copy of the registers and of the column state,
    // the rate arithmetic of the sweep, and the queue of rates still owed.
    // -----------------------------------------------------------------------
    class sweep_scoreboard;
        logic [QW-1:0]   conductivity, vol_capacity, geo_flux, freeze_temp, latent_extra;
        logic [QW-2:0]   half_window;
        logic [QW-1:0]   held_temp, held_thick, held_lower_flux;
        bit              held_valid;
        int unsigned     held_index;
        rate_item_t      owed_rates[$];
        int              errors;

        function new();
            conductivity    = hcrs_pkg::CONDUCTIVITY_RST;
            vol_capacity    = hcrs_pkg::VOL_CAPACITY_RST;
            half_window     = hcrs_pkg::HALF_WINDOW_RST;
            geo_flux        = '0;
            freeze_temp     = '0;
            latent_extra    = '0;
            held_temp       = '0;
            held_thick      = '0;
            held_lower_flux = '0;
            held_valid      = 1'b0;
            held_index      = 0;
            errors          = 0;
        endfunction

        function int pending();
            return owed_rates.size();
        endfunction

        function void write_reg(logic [CW-1:0] idx, logic [QW-1:0] v);
            case (idx)
                hcrs_pkg::CFG_CONDUCTIVITY: conductivity = v;
                hcrs_pkg::CFG_VOL_CAPACITY: vol_capacity = v;
                hcrs_pkg::CFG_GEO_FLUX:     geo_flux     = v;
                hcrs_pkg::CFG_FREEZE_TEMP:  freeze_temp  = v;
                hcrs_pkg::CFG_HALF_WINDOW:  half_window  = v[QW-2:0];
                hcrs_pkg::CFG_LATENT_EXTRA: latent_extra = v;
                default: ;
            endcase
        endfunction

        function longint sx(logic [QW-1:0] v);
            return longint'($signed(v));
        endfunction

        function mag_t abs64(longint v);
            return (v < 0) ? mag_t'(-v) : mag_t'(v);
        endfunction

        // Signed value from sign and magnitude, clamped to the Q16.16 range.
        function longint clamp_q(bit neg, mag_t m);
            if (neg)
                return (m > 64'h8000_0000) ? -longint'(64'h8000_0000) : -longint'(m);
            return (m > 64'h7FFF_FFFF) ? longint'(64'h7FFF_FFFF) : longint'(m);
        endfunction

        // Flux is -k times the (clamped) gradient, clamped again.
        function longint flux_from_grad(bit grad_neg, mag_t grad_mag);
            longint g;
            g = clamp_q(grad_neg, grad_mag);
            return clamp_q(g > 0, (mag_t'(conductivity) * abs64(g)) >> 16);
        endfunction

        function longint inner_flux(logic [QW-1:0] factor, longint diff);
            return flux_from_grad(diff < 0, (mag_t'(factor) * abs64(diff)) >> 16);
        endfunction

        // Top edge: gradient over half the cell, i.e. dT * 2 / thickness.
        function longint top_flux(longint diff, logic [QW-1:0] thick);
            mag_t m, g;
            m = abs64(diff);
            if (m == 0)
                g = 0;
            else if (thick == 0)
                g = 64'h8000_0000;
            else
                g = (m << 17) / mag_t'(thick);
            return flux_from_grad(diff < 0, g);
        endfunction

        function mag_t capacity_at(longint t);
            mag_t cap;
            cap = mag_t'(vol_capacity);
            if (abs64(t - sx(freeze_temp)) <= mag_t'(half_window))
                cap += mag_t'(latent_extra);
            return cap;
        endfunction

        // Magnitude is divided first by the capacity, then by the thickness
        // with a 16 bit fractional tail; the sign goes on last.
        function logic [RW-1:0] cell_rate(longint num, mag_t cap, logic [QW-1:0] thick);
            mag_t m, lim, a, q, rem, r, th;
            bit   neg;
            neg = num < 0;
            m   = abs64(num);
            lim = neg ? 64'h8000_0000_0000 : 64'h7FFF_FFFF_FFFF;
            th  = mag_t'(thick);
            if (m == 0)
                return '0;
            if (cap == 0 || th == 0) begin
                r = lim;
            end else begin
                a   = (m << 24) / cap;
                q   = a / th;
                rem = a % th;
                if (q >= 64'h8000_0000) begin
                    r = lim;
                end else begin
                    r = (q << 16) + ((rem << 16) / th);
                    if (r > lim)
                        r = lim;
                end
            end
            return RW'(neg ? (64'd0 - r) : r);
        endfunction

        // An accepted cell releases the rate of the held cell (it brings the
        // factor of the shared edge), and a top cell also releases its own.
        function void take_cell(cell_t c);
            longint t, lower, q, held_t;
            t = longint'(c.temperature);
            if (!held_valid) begin
                lower = sx(geo_flux);
            end else begin
                held_t = sx(held_temp);
                q      = inner_flux(c.edge_factor, t - held_t);
                owed_rates.push_back('{rate: cell_rate(sx(held_lower_flux) - q,
                                                       capacity_at(held_t), held_thick),
                                       cell_index: IW'(held_index), sweep_done: 1'b0});
                held_index = (held_index + 1 >= hcrs_pkg::MAX_CELLS) ? 0 : held_index + 1;
                lower      = q;
            end
            if (c.is_top) begin
                q = top_flux(longint'(c.surface_temp) - t, c.thickness);
                owed_rates.push_back('{rate: cell_rate(lower - q, capacity_at(t), c.thickness),
                                       cell_index: IW'(held_index), sweep_done: 1'b1});
                held_valid      = 1'b0;
                held_index      = 0;
                held_temp       = '0;
                held_thick      = '0;
                held_lower_flux = '0;
            end else begin
                held_temp       = c.temperature;
                held_thick      = c.thickness;
                held_lower_flux = QW'(lower);
                held_valid      = 1'b1;
            end
        endfunction

        function void check_rate(rate_item_t got);
            rate_item_t want;
            if (owed_rates.size() == 0) begin
                errors++;
                if (errors <= REPORT_LIMIT)
                    $display("%0t: rate item with none expected: actual rate %h index %0d done %b",
                             $time, got.rate, got.cell_index, got.sweep_done);
                return;
            end
            want = owed_rates.pop_front();
            if (got.rate !== want.rate) begin
                errors++;
                if (errors <= REPORT_LIMIT)
                    $display("%0t: rate of cell %0d: expected %h, actual %h",
                             $time, want.cell_index, want.rate, got.rate);
            end
            if (got.cell_index !== want.cell_index) begin
                errors++;
                if (errors <= REPORT_LIMIT)
                    $display("%0t: cell_index: expected %0d, actual %0d",
                             $time, want.cell_index, got.cell_index);
            end
            if (got.sweep_done !== want.sweep_done) begin
                errors++;
                if (errors <= REPORT_LIMIT)
                    $display("%0t: sweep_done of cell %0d: expected %b, actual %b",
                             $time, want.cell_index, want.sweep_done, got.sweep_done);
            end
        endfunction
    endclass

    // -----------------------------------------------------------------------
    // Block under test and its signals.
    // -----------------------------------------------------------------------
    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_valid;
    logic                 o_stall;
    logic signed [QW-1:0] i_temperature;
    logic        [QW-1:0] i_edge_factor;
    logic        [QW-1:0] i_thickness;
    logic signed [QW-1:0] i_surface_temp;
    logic                 i_is_top;
    logic                 o_valid;
    logic                 i_stall;
    logic signed [RW-1:0] o_rate;
    logic        [IW-1:0] o_cell_index;
    logic                 o_sweep_done;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic        [CW-1:0] i_cfg_index;
    logic        [QW-1:0] i_cfg_data;

    heat_conduction_rate_sweep DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_temperature  (i_temperature),
        .i_edge_factor  (i_edge_factor),
        .i_thickness    (i_thickness),
        .i_surface_temp (i_surface_temp),
        .i_is_top       (i_is_top),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_rate         (o_rate),
        .o_cell_index   (o_cell_index),
        .o_sweep_done   (o_sweep_done),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    sweep_scoreboard sb;
    // Set by the stimulus to request the long receiver hold-off; the
    // receiver process clears it once the hold-off is over.
    bit              pressure_on;
    cell_t           seen_cell;
    rate_item_t      seen_rate;

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // -----------------------------------------------------------------------
    // Observation. Everything is sampled right after the rising edge, before
    // any nonblocking update of that edge lands, so each handshake is seen
    // with the values the block saw. Register writes and cells are applied to
    // the scoreboard before rates are checked within the same edge.
    // -----------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready)
                sb.write_reg(i_cfg_index, i_cfg_data);
            if (i_valid && !o_stall) begin
                seen_cell.temperature  = i_temperature;
                seen_cell.edge_factor  = i_edge_factor;
                seen_cell.thickness    = i_thickness;
                seen_cell.surface_temp = i_surface_temp;
                seen_cell.is_top       = i_is_top;
                sb.take_cell(seen_cell);
            end
            if (o_valid && !i_stall) begin
                seen_rate.rate       = o_rate;
                seen_rate.cell_index = o_cell_index;
                seen_rate.sweep_done = o_sweep_done;
                sb.check_rate(seen_rate);
            end
        end
    end

    // -----------------------------------------------------------------------
    // Receiver pacing. Stretches of free flow and of stall follow in random order,
    // mostly short, sometimes long, with occasional long stretches of no stall at
    // all. Exactly one drive of i_stall happens per stretch boundary.
    // -----------------------------------------------------------------------
    initial begin : receiver_pacing
        int unsigned r;
        forever begin
            if (pressure_on) begin
                // Hold the output for a long time while the sender keeps
                // offering cells, so that the block fills up and pushes
                // back on its input.
                i_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                pressure_on = 1'b0;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 45) begin
                    i_stall <= 1'b0;
                    repeat ($urandom_range(1, 6)) @(posedge i_clk);
                end else if (r < 85) begin
                    i_stall <= 1'b1;
                    repeat ($urandom_range(1, 3)) @(posedge i_clk);
                end else if (r < 95) begin
                    i_stall <= 1'b1;
                    repeat ($urandom_range(4, 25)) @(posedge i_clk);
                end else begin
                    i_stall <= 1'b0;
                    repeat ($urandom_range(40, 150)) @(posedge i_clk);
                end
            end
        end
    end

    // Hard stop. The slowest correct run (about 5000 cells plus the longest gaps
    // and stalls) ends well before it.
    initial begin : watchdog
        #100_000_000;
        $display("status: fail");
        $finish;
    end

    // -----------------------------------------------------------------------
    // Stimulus helpers.
    // -----------------------------------------------------------------------

    // Sender idle time before an item: usually none, now and then long.
    function automatic int unsigned sender_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 20);
        return $urandom_range(30, 60);
    endfunction

    // Offer one cell and wait until it is taken. Valid is only lowered when
    // an idle gap actually follows, so back-to-back items keep it high.
    task automatic send_cell(input cell_t c);
        int unsigned idle;
        idle = pressure_on ? 0 : sender_gap();
        if (idle != 0) begin
            i_valid <= 1'b0;
            repeat (idle) @(posedge i_clk);
        end
        i_valid        <= 1'b1;
        i_temperature  <= c.temperature;
        i_edge_factor  <= c.edge_factor;
        i_thickness    <= c.thickness;
        i_surface_temp <= c.surface_temp;
        i_is_top       <= c.is_top;
        do @(posedge i_clk); while (o_stall);
    endtask

    // Stop offering, wait for every owed rate, then let the block settle.
    task automatic drain_column();
        i_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CW-1:0] idx, input logic [QW-1:0] v);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    // Value for one register: its lowest or highest legal value, or a mix of
    // physically plausible values, extremes and fully random words.
    function automatic logic [QW-1:0] pick_reg(input logic [CW-1:0] idx, input setting_e how);
        logic [QW-1:0] lo, hi, v;
        int unsigned   r;
        case (idx)
            hcrs_pkg::CFG_CONDUCTIVITY: begin
                lo = 32'd1;
                hi = 32'hFFFF_FFFF;
                v  = $urandom_range(1 << 12, 16 << 16);
            end
            hcrs_pkg::CFG_VOL_CAPACITY: begin
                lo = 32'd1;
                hi = 32'hFFFF_FFFF;
                v  = $urandom_range(1, 4_000_000);
            end
            hcrs_pkg::CFG_GEO_FLUX: begin
                lo = 32'h8000_0000;
                hi = 32'h7FFF_FFFF;
                v  = $urandom_range(0, 8 << 16) - (4 << 16);
            end
            hcrs_pkg::CFG_FREEZE_TEMP: begin
                lo = 32'h8000_0000;
                hi = 32'h7FFF_FFFF;
                v  = $urandom_range(0, 20 << 16) - (10 << 16);
            end
            hcrs_pkg::CFG_HALF_WINDOW: begin
                lo = 32'd0;
                hi = 32'h7FFF_FFFF;
                v  = $urandom_range(0, 2 << 16);
            end
            default: begin
                lo = 32'd0;
                hi = 32'hFFFF_FFFF;
                v  = $urandom_range(0, 50_000_000);
            end
        endcase
        r = $urandom_range(0, 99);
        if (how == SET_LOW || (how == SET_MIXED && r < 8))
            return lo;
        if (how == SET_HIGH || (how == SET_MIXED && r < 16))
            return hi;
        if (r < 26) begin
            v = $urandom();
            if (idx == hcrs_pkg::CFG_HALF_WINDOW)
                v[QW-1] = 1'b0;
            if (v == 0 && lo != 0)
                v = 32'd1;
        end
        return v;
    endfunction

    task automatic program_regs(input setting_e how);
        write_reg(hcrs_pkg::CFG_CONDUCTIVITY, pick_reg(hcrs_pkg::CFG_CONDUCTIVITY, how));
        write_reg(hcrs_pkg::CFG_VOL_CAPACITY, pick_reg(hcrs_pkg::CFG_VOL_CAPACITY, how));
        write_reg(hcrs_pkg::CFG_GEO_FLUX,     pick_reg(hcrs_pkg::CFG_GEO_FLUX, how));
        write_reg(hcrs_pkg::CFG_FREEZE_TEMP,  pick_reg(hcrs_pkg::CFG_FREEZE_TEMP, how));
        write_reg(hcrs_pkg::CFG_HALF_WINDOW,  pick_reg(hcrs_pkg::CFG_HALF_WINDOW, how));
        write_reg(hcrs_pkg::CFG_LATENT_EXTRA, pick_reg(hcrs_pkg::CFG_LATENT_EXTRA, how));
        i_cfg_valid <= 1'b0;
    endtask

    // Temperatures: full-range words, values right at the phase window
    // boundaries, values around the freezing point and moderate values.
    function automatic logic [QW-1:0] pick_temp();
        int unsigned   r;
        logic [QW-1:0] rim;
        r = $urandom_range(0, 99);
        if (r < 25)
            return $urandom();
        if (r < 40) begin
            rim = r[0] ? sb.freeze_temp + {1'b0, sb.half_window}
                       : sb.freeze_temp - {1'b0, sb.half_window};
            return rim + $urandom_range(0, 2) - 1;
        end
        if (r < 60)
            return sb.freeze_temp + $urandom_range(0, 4 << 16) - (2 << 16);
        return $urandom_range(0, 200 << 16) - (100 << 16);
    endfunction

    function automatic cell_t random_cell(input bit top);
        cell_t       c;
        int unsigned r;
        c.temperature  = pick_temp();
        c.surface_temp = pick_temp();
        c.is_top       = top;
        r = $urandom_range(0, 99);
        if (r < 25)      c.edge_factor = $urandom();
        else if (r < 80) c.edge_factor = $urandom_range(0, 4 << 16);
        else if (r < 90) c.edge_factor = 32'd0;
        else             c.edge_factor = 32'hFFFF_FFFF;
        r = $urandom_range(0, 99);
        if (r < 20)      c.thickness = $urandom();
        else if (r < 70) c.thickness = $urandom_range(1 << 12, 4 << 16);
        else if (r < 80) c.thickness = $urandom_range(1, 16);
        else if (r < 90) c.thickness = 32'hFFFF_FFFF;
        else             c.thickness = $urandom_range(1 << 16, 64 << 16);
        if (c.thickness == 0)
            c.thickness = 32'd1;
        return c;
    endfunction

    function automatic cell_t mk_cell(input logic [QW-1:0] t, input logic [QW-1:0] ef,
                                      input logic [QW-1:0] th, input logic [QW-1:0] st,
                                      input bit top);
        cell_t c;
        c.temperature  = t;
        c.edge_factor  = ef;
        c.thickness    = th;
        c.surface_temp = st;
        c.is_top       = top;
        return c;
    endfunction

    // Column length: single-cell columns, short columns and a few tall ones.
    function automatic int unsigned column_length();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 12) return 1;
        if (r < 88) return $urandom_range(2, 8);
        return $urandom_range(9, 30);
    endfunction

    // -----------------------------------------------------------------------
    // Main sequence.
    // -----------------------------------------------------------------------
    initial begin : stimulus
        int unsigned sent, len, k;
        int          phase;

        sb             = new();
        pressure_on    = 1'b0;
        i_rst_n        <= 1'b0;
        i_valid        <= 1'b0;
        i_temperature  <= '0;
        i_edge_factor  <= '0;
        i_thickness    <= '0;
        i_surface_temp <= '0;
        i_is_top       <= 1'b0;
        i_cfg_valid    <= 1'b0;
        i_cfg_index    <= '0;
        i_cfg_data     <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        // Directed columns with the reset register values.
        // Single-cell columns: the first item is already the top cell, so
        // exactly one rate comes out with sweep_done set. The second one has
        // the largest surface step over the thinnest cell, which saturates
        // the gradient and the flux.
        send_cell(mk_cell(32'h0000_0000, 32'hFFFF_FFFF, 32'h0001_0000, 32'h7FFF_FFFF, 1'b1));
        send_cell(mk_cell(32'h8000_0000, 32'h0000_0000, 32'h0000_0001, 32'h7FFF_FFFF, 1'b1));
        // Field extremes. The bottom cell carries a full edge factor that
        // must be ignored; the next edge sees the widest temperature swing.
        send_cell(mk_cell(32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0001, 32'h8000_0000, 1'b0));
        send_cell(mk_cell(32'h8000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000, 1'b0));
        send_cell(mk_cell(32'h0000_0000, 32'h0000_0000, 32'h0000_0001, 32'hFFFF_FFFF, 1'b0));
        send_cell(mk_cell(32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 32'h8000_0000, 1'b1));
        drain_column();

        // Phase change window: with latent heat switched on, cells sit at
        // the center, exactly on both window edges and just outside them.
        // The top cell matches the surface temperature, so its top flux is 0.
        write_reg(hcrs_pkg::CFG_LATENT_EXTRA, 32'd1_000_000);
        i_cfg_valid <= 1'b0;
        send_cell(mk_cell(32'h0000_0000, 32'h0001_0000, 32'h0001_0000, 32'h0000_0000, 1'b0));
        send_cell(mk_cell(32'h0001_0000, 32'h0002_0000, 32'h0001_0000, 32'h0000_0000, 1'b0));
        send_cell(mk_cell(32'h0001_0001, 32'h0001_0000, 32'h0000_8000, 32'h0000_0000, 1'b0));
        send_cell(mk_cell(32'hFFFF_0000, 32'h0001_0000, 32'h0001_0000, 32'h0000_0000, 1'b0));
        send_cell(mk_cell(32'hFFFE_FFFF, 32'h0001_0000, 32'hFFFF_FFFF, 32'hFFFE_FFFF, 1'b1));
        drain_column();

        // Random columns under a sequence of register settings: all lowest
        // values, all highest values, then mixed settings. Each phase ends
        // on a top cell, so the block is idle when the registers change.
        for (phase = 0; phase < PHASES; phase++) begin
            program_regs(phase == 0 ? SET_LOW : (phase == 1 ? SET_HIGH : SET_MIXED));
            sent = 0;
            while (sent < PHASE_CELLS) begin
                len = column_length();
                for (k = 0; k < len; k++) begin
                    send_cell(random_cell(k == len - 1));
                    sent++;
                    if (phase == 2 && sent == 30)
                        pressure_on = 1'b1;
                end
            end
            drain_column();
        end

        // One column taller than the counter span, so the cell index wraps
        // back to zero before the top cell arrives.
        program_regs(SET_MIXED);
        for (k = 0; k < hcrs_pkg::MAX_CELLS + 2; k++)
            send_cell(random_cell(k == hcrs_pkg::MAX_CELLS + 1));
        drain_column();

        if (sb.errors == 0 && sb.pending() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+src
src/hcrs_pkg.sv
src/hcrs_mul.sv
src/hcrs_div.sv
src/heat_conduction_rate_sweep.sv
src/hcrs_checker.sv
tb/tb_heat_conduction_rate_sweep.sv
